/* rtl/point_lexicographic_sorter_macros.svh */
// Assertion macros used by the checker file of the point sorter.
`ifndef POINT_LEXICOGRAPHIC_SORTER_MACROS_SVH
`define POINT_LEXICOGRAPHIC_SORTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// Shared constants, types and the point order for the point sorter.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COORD_W    = 32;
	localparam int PT_W       = 2 * COORD_W;
	localparam int SPAN_W     = 2 * IDX_W;

	localparam logic OPC_LOAD  = 1'b0;
	localparam logic OPC_FETCH = 1'b1;

	typedef enum logic [10:0] {
		S_LOAD   = 11'b000_0000_0001,
		S_FETCH  = 11'b000_0000_0010,
		S_INIT   = 11'b000_0000_0100,
		S_POP    = 11'b000_0000_1000,
		S_RANGE  = 11'b000_0001_0000,
		S_PIVOT  = 11'b000_0010_0000,
		S_SCANI  = 11'b000_0100_0000,
		S_SCANJ  = 11'b000_1000_0000,
		S_SWAP   = 11'b001_0000_0000,
		S_PUSHHI = 11'b010_0000_0000,
		S_PUSHLO = 11'b100_0000_0000
	} state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_FETCH,
		DP_INIT,
		DP_POP,
		DP_RANGE,
		DP_PIVOT,
		DP_SCAN_I,
		DP_SCAN_J,
		DP_SWAP,
		DP_PUSH_HI,
		DP_PUSH_LO
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   fetching;
	} dp_cmd_t;

	typedef struct packed {
		logic count_lt2;
		logic depth_zero;
		logic lo_ge_hi;
		logic i_more;
		logic j_more;
		logic i_ge_j;
		logic out_busy;
	} dp_status_t;

	// Point a sorts before point b: by x, then by y, both signed.
	function automatic logic pt_before(input logic [PT_W-1:0] a, input logic [PT_W-1:0] b);
		logic signed [COORD_W-1:0] ax, ay, bx, by;
		ax = a[PT_W-1:COORD_W];
		ay = a[COORD_W-1:0];
		bx = b[PT_W-1:COORD_W];
		by = b[COORD_W-1:0];
		return (ax < bx) || ((ax == bx) && (ay < by));
	endfunction

endpackage

/* rtl/pls_ram.sv */
// ----------------------------------------------------------------------------
// pls_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pls_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/pls_ctrl.sv */
// ----------------------------------------------------------------------------
// pls_ctrl
// Sequencer for loading, fetching and the stack-driven partition sort.
// ----------------------------------------------------------------------------
module pls_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic                last_point,
	input  pls_pkg::dp_status_t st,
	output pls_pkg::dp_cmd_t    cmd
);
	import pls_pkg::*;

	state_t state_q, state_d;
	logic   idle;
	logic   acc;

	assign idle     = (state_q == S_LOAD) || (state_q == S_FETCH);
	assign in_stall = !idle || st.out_busy;
	assign acc      = in_valid && !in_stall;

	always_comb begin
		state_d      = state_q;
		cmd.op       = DP_NONE;
		cmd.fetching = (state_q == S_FETCH);
		unique case (state_q)
			S_LOAD, S_FETCH: begin
				if (acc) begin
					if (op == OPC_LOAD) begin
						cmd.op = DP_LOAD;
						state_d = last_point ? S_INIT : S_LOAD;
					end else begin
						cmd.op = DP_FETCH;
					end
				end
			end
			S_INIT: begin
				cmd.op = DP_INIT;
				state_d = st.count_lt2 ? S_FETCH : S_POP;
			end
			S_POP: begin
				if (st.depth_zero) begin
					state_d = S_FETCH;
				end else begin
					cmd.op = DP_POP;
					state_d = S_RANGE;
				end
			end
			S_RANGE: begin
				cmd.op = DP_RANGE;
				state_d = st.lo_ge_hi ? S_POP : S_PIVOT;
			end
			S_PIVOT: begin
				cmd.op = DP_PIVOT;
				state_d = S_SCANI;
			end
			S_SCANI: begin
				cmd.op = DP_SCAN_I;
				if (!st.i_more) begin
					state_d = S_SCANJ;
				end
			end
			S_SCANJ: begin
				cmd.op = DP_SCAN_J;
				if (!st.j_more) begin
					state_d = st.i_ge_j ? S_PUSHHI : S_SWAP;
				end
			end
			S_SWAP: begin
				cmd.op = DP_SWAP;
				state_d = S_SCANI;
			end
			S_PUSHHI: begin
				cmd.op = DP_PUSH_HI;
				state_d = S_PUSHLO;
			end
			S_PUSHLO: begin
				cmd.op = DP_PUSH_LO;
				state_d = S_POP;
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/pls_dp.sv */
// ----------------------------------------------------------------------------
// pls_dp
// Point store, range stack, partition registers and the output register.
// ----------------------------------------------------------------------------
module pls_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pls_pkg::dp_cmd_t            cmd,
	output pls_pkg::dp_status_t         st,
	input  logic [pls_pkg::COORD_W-1:0] x_coord,
	input  logic [pls_pkg::COORD_W-1:0] y_coord,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pls_pkg::COORD_W-1:0] out_x,
	output logic [pls_pkg::COORD_W-1:0] out_y,
	output logic                        final_point,
	output logic                        status,
	output logic                        overflowed
);
	import pls_pkg::*;

	logic [CNT_W-1:0]  count_q, rd_idx_q, depth_q;
	logic              ovf_q;
	logic [IDX_W-1:0]  lo_q, hi_q, i_q, j_q;
	logic [PT_W-1:0]   pivot_q, vi_q, vj_q;
	logic              out_valid_q, out_empty_q, out_final_q, out_ovf_q;

	logic              pt_we, pt_re;
	logic [IDX_W-1:0]  pt_waddr, pt_raddr;
	logic [PT_W-1:0]   pt_wdata, pt_rd;
	logic              stk_we, stk_re;
	logic [IDX_W-1:0]  stk_waddr, stk_raddr;
	logic [SPAN_W-1:0] stk_wdata, stk_rd;
	logic [IDX_W-1:0]  stk_lo, stk_hi;

	logic [CNT_W-1:0]  eff_count;
	logic              room;
	logic              hit;
	logic              depth_ok;
	logic              push_hi_ok, push_lo_ok;

	assign stk_lo     = stk_rd[SPAN_W-1:IDX_W];
	assign stk_hi     = stk_rd[IDX_W-1:0];
	assign eff_count  = cmd.fetching ? '0 : count_q;
	assign room       = eff_count < CNT_W'(MAX_POINTS);
	assign hit        = cmd.fetching && (rd_idx_q < count_q);
	assign depth_ok   = depth_q < CNT_W'(MAX_POINTS);
	// The left part ends at j; each side is pushed only when it holds two or more points.
	assign push_hi_ok = (({1'b0, j_q} + CNT_W'(1)) < {1'b0, hi_q}) && depth_ok;
	assign push_lo_ok = (lo_q < j_q) && depth_ok;

	assign st.count_lt2  = count_q < CNT_W'(2);
	assign st.depth_zero = depth_q == '0;
	assign st.lo_ge_hi   = stk_lo >= stk_hi;
	assign st.i_more     = (i_q < hi_q) && pt_before(pt_rd, pivot_q);
	assign st.j_more     = (j_q > lo_q) && pt_before(pivot_q, pt_rd);
	assign st.i_ge_j     = i_q >= j_q;
	assign st.out_busy   = out_valid_q && out_stall;

	always_comb begin
		pt_we     = 1'b0;
		pt_waddr  = eff_count[IDX_W-1:0];
		pt_wdata  = {x_coord, y_coord};
		pt_re     = 1'b0;
		pt_raddr  = rd_idx_q[IDX_W-1:0];
		stk_we    = 1'b0;
		stk_waddr = depth_q[IDX_W-1:0];
		stk_wdata = {lo_q, j_q};
		stk_re    = 1'b0;
		stk_raddr = IDX_W'(depth_q - CNT_W'(1));
		unique case (cmd.op)
			DP_LOAD: begin
				pt_we = room;
			end
			DP_FETCH: begin
				pt_re = hit;
			end
			DP_INIT: begin
				stk_we    = !st.count_lt2;
				stk_waddr = '0;
				stk_wdata = {IDX_W'(0), IDX_W'(count_q - CNT_W'(1))};
			end
			DP_POP: begin
				stk_re = 1'b1;
			end
			DP_RANGE: begin
				pt_re    = 1'b1;
				pt_raddr = stk_lo;
			end
			DP_PIVOT: begin
				pt_re    = 1'b1;
				pt_raddr = lo_q;
			end
			DP_SCAN_I: begin
				pt_re    = 1'b1;
				pt_raddr = st.i_more ? i_q + IDX_W'(1) : j_q;
			end
			DP_SCAN_J: begin
				if (st.j_more) begin
					pt_re    = 1'b1;
					pt_raddr = j_q - IDX_W'(1);
				end else if (!st.i_ge_j) begin
					pt_we    = 1'b1;
					pt_waddr = j_q;
					pt_wdata = vi_q;
				end
			end
			DP_SWAP: begin
				// Position j was written last cycle, so reading i + 1 sees the new value.
				pt_we    = 1'b1;
				pt_waddr = i_q;
				pt_wdata = vj_q;
				pt_re    = 1'b1;
				pt_raddr = i_q + IDX_W'(1);
			end
			DP_PUSH_HI: begin
				stk_we    = push_hi_ok;
				stk_wdata = {j_q + IDX_W'(1), hi_q};
			end
			DP_PUSH_LO: begin
				stk_we = push_lo_ok;
			end
			default: begin
			end
		endcase
	end

	pls_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.re    (pt_re),
		.raddr (pt_raddr),
		.rdata (pt_rd)
	);

	pls_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_POINTS)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_idx_q    <= '0;
			depth_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				DP_LOAD: begin
					if (cmd.fetching) begin
						rd_idx_q <= '0;
					end
					if (room) begin
						count_q <= eff_count + CNT_W'(1);
					end else begin
						count_q <= eff_count;
						ovf_q   <= 1'b1;
					end
				end
				DP_FETCH: begin
					out_valid_q <= 1'b1;
					if (hit) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
				end
				DP_INIT: begin
					rd_idx_q <= '0;
					depth_q  <= st.count_lt2 ? '0 : CNT_W'(1);
				end
				DP_POP: begin
					depth_q <= depth_q - CNT_W'(1);
				end
				DP_PUSH_HI: begin
					if (push_hi_ok) begin
						depth_q <= depth_q + CNT_W'(1);
					end
				end
				DP_PUSH_LO: begin
					if (push_lo_ok) begin
						depth_q <= depth_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_FETCH: begin
				out_empty_q <= !hit;
				out_final_q <= hit && ((rd_idx_q + CNT_W'(1)) == count_q);
				out_ovf_q   <= ovf_q;
			end
			DP_RANGE: begin
				lo_q <= stk_lo;
				hi_q <= stk_hi;
			end
			DP_PIVOT: begin
				pivot_q <= pt_rd;
				i_q     <= lo_q;
				j_q     <= hi_q;
			end
			DP_SCAN_I: begin
				if (st.i_more) begin
					i_q <= i_q + IDX_W'(1);
				end else begin
					vi_q <= pt_rd;
				end
			end
			DP_SCAN_J: begin
				if (st.j_more) begin
					j_q <= j_q - IDX_W'(1);
				end else begin
					vj_q <= pt_rd;
				end
			end
			DP_SWAP: begin
				i_q <= i_q + IDX_W'(1);
				j_q <= j_q - IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_empty_q ? '0 : pt_rd[PT_W-1:COORD_W];
	assign out_y       = out_empty_q ? '0 : pt_rd[COORD_W-1:0];
	assign final_point = out_final_q;
	assign status      = out_empty_q;
	assign overflowed  = out_ovf_q;

endmodule

/* rtl/point_lexicographic_sorter.sv */
// Loads are accepted back to back unless the input stalls as described below.
// A fetch is accepted every cycle while not stalled; its item appears in the next cycle.
// Input stalls during the sort and while a finished result item is held by out_stall.
// The sort uses the single point-store read port for every compare and every swap;
// each range also passes the POP, RANGE, PIVOT, PUSHHI and PUSHLO states.
// Reset (arst_n low) clears counters, flags and the phase; the point store is not cleared.
// ----------------------------------------------------------------------------
// point_lexicographic_sorter
// Collects signed (x, y) points, sorts them by x then y, and returns them in order.
// ----------------------------------------------------------------------------
module point_lexicographic_sorter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic [pls_pkg::COORD_W-1:0] x_coord,
	input  logic [pls_pkg::COORD_W-1:0] y_coord,
	input  logic                        last_point,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pls_pkg::COORD_W-1:0] out_x,
	output logic [pls_pkg::COORD_W-1:0] out_y,
	output logic                        final_point,
	output logic                        status,
	output logic                        overflowed
);
	import pls_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	pls_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.last_point (last_point),
		.st         (st),
		.cmd        (cmd)
	);

	pls_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_x       (out_x),
		.out_y       (out_y),
		.final_point (final_point),
		.status      (status),
		.overflowed  (overflowed)
	);

endmodule

/* rtl/pls_checker.sv */
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks on the point sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_lexicographic_sorter_macros.svh"

module pls_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        op,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [pls_pkg::COORD_W-1:0] out_x,
	input logic [pls_pkg::COORD_W-1:0] out_y,
	input logic                        final_point,
	input logic                        status
);
	import pls_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	`PLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped while stalled")
	`PLS_ASSERT_NOW(a_empty_zero, out_valid && status, (out_x == '0) && (out_y == '0) && !final_point, "empty result item carries data")
	`PLS_ASSERT_NEXT(a_load_quiet, in_acc && (op == OPC_LOAD), !out_valid, "load produced a result item")
	`PLS_ASSERT_NEXT(a_fetch_result, in_acc && (op == OPC_FETCH), out_valid, "fetch produced no result item")

endmodule

bind point_lexicographic_sorter pls_checker u_pls_checker (.*);
